FILE: rtl/binary_gcd_subtract_unit_defines.svh
// Assertion macros shared by the binary GCD unit's checker.
`ifndef BINARY_GCD_SUBTRACT_UNIT_DEFINES_SVH
`define BINARY_GCD_SUBTRACT_UNIT_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define BGCD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, for a property that needs no reset qualifier beyond the one given.
`define BGCD_ASSERT_RST(label, clk, rst_n, prop, msg) \
	`BGCD_ASSERT(label, clk, rst_n, prop, msg)

`endif

FILE: rtl/bgcd_pkg.sv
// Types and constants of the binary GCD unit.
package bgcd_pkg;

	localparam int OPND_W   = 32;
	localparam int S_DATA_W = 64;
	localparam int M_DATA_W = 32;

	// How the front end sorts a word.
	typedef enum logic [1:0] {
		KIND_ITER,
		KIND_PASS_B,
		KIND_BOTH_ZERO
	} kind_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} eng_state_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

FILE: rtl/bgcd_front.sv
// Front end: takes input words, trims operands and sorts out the trivial cases.
module bgcd_front import bgcd_pkg::*; #(
	parameter int WIDTH = 32,
	parameter int EW    = 66
) (
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
	input  q_status_t           q_status,
	output logic                push,
	output logic [EW-1:0]       push_data
);

	logic [WIDTH-1:0] opnd_a;
	logic [WIDTH-1:0] opnd_b;
	kind_t            kind;

	assign opnd_a = WIDTH'(s_tdata[OPND_W-1:0]);
	assign opnd_b = WIDTH'(s_tdata[S_DATA_W-1:OPND_W]);

	always_comb begin
		if (opnd_a == '0 && opnd_b == '0) begin
			kind = KIND_BOTH_ZERO;
		end else if (opnd_a == '0) begin
			kind = KIND_PASS_B;
		end else begin
			kind = KIND_ITER;
		end
	end

	assign s_tready  = !q_status.full;
	assign push      = s_tvalid && !q_status.full;
	assign push_data = {kind, opnd_b, opnd_a};

endmodule

FILE: rtl/bgcd_queue.sv
// Two-entry queue between the front end and the GCD engine.
module bgcd_queue import bgcd_pkg::*; #(
	parameter int EW = 66
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [EW-1:0] push_data,
	input  logic          pop,
	output logic [EW-1:0] pop_data,
	output q_status_t     q_status
);

	localparam int DEPTH = 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	logic [EW-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign pop_data       = mem_q[rd_ptr_q];
	assign q_status.empty = (count_q == '0);
	assign q_status.full  = (count_q == CW'(DEPTH));

endmodule

FILE: rtl/bgcd_back.sv
// GCD engine: one halve, subtract or swap step per cycle, plus the output register.
module bgcd_back import bgcd_pkg::*; #(
	parameter int WIDTH = 32,
	parameter int EW    = 66
) (
	input  logic                clk,
	input  logic                arst_n,
	input  q_status_t           q_status,
	input  logic [EW-1:0]       pop_data,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // divisor [31:0]
	output logic [0:0]          m_tuser    // invalid_input [0]
);

	localparam int CNT_W = $clog2(WIDTH);

	eng_state_t          state_q, state_d;
	logic [WIDTH-1:0]    a_q, a_d;
	logic [WIDTH-1:0]    b_q, b_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic                out_valid_q;
	logic [M_DATA_W-1:0] out_div_q;
	logic                out_inv_q;

	logic                out_free;
	logic [WIDTH-1:0]    pop_a;
	logic [WIDTH-1:0]    pop_b;
	kind_t               pop_kind;
	logic [WIDTH-1:0]    diff;
	logic                load_out;
	logic [WIDTH-1:0]    ld_div;
	logic                ld_inv;

	assign out_free = !out_valid_q || m_tready;
	assign pop_a    = pop_data[WIDTH-1:0];
	assign pop_b    = pop_data[2*WIDTH-1:WIDTH];
	assign pop_kind = kind_t'(pop_data[EW-1:2*WIDTH]);
	assign diff     = a_q - b_q;

	always_comb begin
		state_d  = state_q;
		a_d      = a_q;
		b_d      = b_q;
		cnt_d    = cnt_q;
		pop      = 1'b0;
		load_out = 1'b0;
		ld_div   = '0;
		ld_inv   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!q_status.empty) begin
					case (pop_kind)
						KIND_ITER: begin
							pop     = 1'b1;
							a_d     = pop_a;
							b_d     = pop_b;
							cnt_d   = '0;
							state_d = ST_RUN;
						end
						KIND_PASS_B: begin
							if (out_free) begin
								pop      = 1'b1;
								load_out = 1'b1;
								ld_div   = pop_b;
							end
						end
						KIND_BOTH_ZERO: begin
							if (out_free) begin
								pop      = 1'b1;
								load_out = 1'b1;
								ld_inv   = 1'b1;
							end
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			ST_RUN: begin
				if (!a_q[0] && !b_q[0]) begin
					a_d   = a_q >> 1;
					b_d   = b_q >> 1;
					cnt_d = cnt_q + CNT_W'(1);
				end else if (!a_q[0]) begin
					a_d = a_q >> 1;
				end else if (b_q == '0) begin
					// a is odd here; hold the result until the output slot frees up
					if (out_free) begin
						load_out = 1'b1;
						ld_div   = a_q << cnt_q;
						state_d  = ST_IDLE;
					end
				end else if (a_q >= b_q) begin
					a_d = b_q;
					b_d = diff;
				end else begin
					a_d = b_q;
					b_d = a_q;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		a_q   <= a_d;
		b_q   <= b_d;
		cnt_q <= cnt_d;
		if (load_out) begin
			out_div_q <= M_DATA_W'(ld_div);
			out_inv_q <= ld_inv;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_div_q;
	assign m_tuser[0] = out_inv_q;

endmodule

FILE: rtl/binary_gcd_subtract_unit.sv
// Top level of the binary GCD unit: front end, queue and GCD engine.
//
//   channel | dir | tdata                              | tuser
//   s_*     | in  | operand_a [31:0], operand_b [63:32] | -
//   m_*     | out | divisor [31:0]                     | invalid_input [0]
//
// One step of the engine per cycle: an operand pair runs one halve, subtract or
// swap step at a time, as many as its operands call for. Pairs with a zero first
// operand go straight to the output register; a zero second operand alone still
// runs through the halving steps.
// Reset (arst_n low) empties the queue and drops any pending result word.
// The queue holds two words, so input is taken until it is full while the engine
// runs or the output word waits on m_tready.
module binary_gcd_subtract_unit import bgcd_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // divisor [31:0]
	output logic [0:0]          m_tuser    // invalid_input [0]
);

	localparam int EW = 2 * WIDTH + $bits(kind_t);

	logic          push;
	logic [EW-1:0] push_data;
	logic          pop;
	logic [EW-1:0] pop_data;
	q_status_t     q_status;

	bgcd_front #(
		.WIDTH (WIDTH),
		.EW    (EW)
	) u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	bgcd_queue #(
		.EW (EW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_status  (q_status)
	);

	bgcd_back #(
		.WIDTH (WIDTH),
		.EW    (EW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.pop_data (pop_data),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: rtl/bgcd_checker.sv
// Port checker for the binary GCD unit, bound to the top level.
`include "binary_gcd_subtract_unit_defines.svh"

module bgcd_checker import bgcd_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [S_DATA_W-1:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,   // divisor [31:0]
	input logic [0:0]          m_tuser    // invalid_input [0]
);

	`BGCD_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "result word dropped while stalled")
	`BGCD_ASSERT(a_out_stable, clk, arst_n, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")
	`BGCD_ASSERT_RST(a_inv_zero, clk, arst_n, m_tvalid && m_tuser[0] |-> m_tdata == '0, "invalid word with nonzero divisor")
	`BGCD_ASSERT_RST(a_gcd_nonzero, clk, arst_n, m_tvalid && !m_tuser[0] |-> m_tdata != '0, "valid word with zero divisor")

endmodule

bind binary_gcd_subtract_unit bgcd_checker u_chk (.*);
